### rtl/miq_pkg.sv
// ---------------------------------------------------------------------------
// miq_pkg
// Shared constants, codes, types and index helpers of the middle insert queue.
// ---------------------------------------------------------------------------
package miq_pkg;

   // Capacity of each half and width of a stored element
   localparam int HALF_DEPTH = 512;
   localparam int VALUE_W    = 32;
   localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam int CNT_W      = $clog2(HALF_DEPTH + 1);

   // Operation codes (request tuser)
   localparam logic [1:0] OP_PUSH_TAIL = 2'd0;
   localparam logic [1:0] OP_PUSH_MID  = 2'd1;
   localparam logic [1:0] OP_POP       = 2'd2;

   // Status codes (response tuser)
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic       latch;      // capture the accepted request
      logic       push_tail;  // write at back tail, grow back half
      logic       push_mid;   // step back head down, write there
      logic       pop;        // read front head, shrink front half
      logic       cap_pop;    // capture popped element from read port
      logic       bal_rd;     // read back head, shrink back half
      logic       bal_wr;     // write moved element at front tail
      logic       set_st;     // load status code
      logic [1:0] st_code;
      logic       load_rsp;   // load the response register
   } miq_cmd_type;

   typedef struct packed {
      logic [1:0] op;         // latched operation
      logic       empty;      // front half holds nothing
      logic       full;       // back half holds HALF_DEPTH elements
      logic       need_bal;   // back half longer than front half
      logic       rsp_free;   // response register can take a result
   } miq_stat_type;

   // Reduce head + offset (known below twice the depth) to a store index
   function automatic logic [ADDR_W-1:0] wrap_sum(input logic [ADDR_W:0] sum);
      logic [ADDR_W:0] red;
      red = sum;
      if (sum >= (ADDR_W + 1)'(HALF_DEPTH)) begin
         red = sum - (ADDR_W + 1)'(HALF_DEPTH);
      end
      return red[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] inc_idx(input logic [ADDR_W-1:0] idx);
      return (idx == ADDR_W'(HALF_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] dec_idx(input logic [ADDR_W-1:0] idx);
      return (idx == '0) ? ADDR_W'(HALF_DEPTH - 1) : idx - 1'b1;
   endfunction

endpackage

### rtl/miq_ctrl.sv
// ---------------------------------------------------------------------------
// miq_ctrl
// Sequencer: steps one request through operation, rebalance and response.
// ---------------------------------------------------------------------------
module miq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  miq_pkg::miq_stat_type stat,
   output miq_pkg::miq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_BAL  = 3'd2;
   localparam logic [2:0] S_MOVE = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_st = 1'b1;
            cmd.st_code = miq_pkg::ST_OK;
            state_in = S_RESP;
            unique case (stat.op) inside
               miq_pkg::OP_PUSH_TAIL, miq_pkg::OP_PUSH_MID: begin
                  if (stat.full) begin
                     cmd.st_code = miq_pkg::ST_FULL;
                  end else begin
                     cmd.push_tail = (stat.op == miq_pkg::OP_PUSH_TAIL);
                     cmd.push_mid  = (stat.op == miq_pkg::OP_PUSH_MID);
                     state_in      = S_BAL;
                  end
               end
               miq_pkg::OP_POP: begin
                  if (stat.empty) begin
                     cmd.st_code = miq_pkg::ST_EMPTY;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = S_BAL;
                  end
               end
               default: ;
            endcase
         end
         S_BAL: begin
            cmd.cap_pop = (stat.op == miq_pkg::OP_POP);
            if (stat.need_bal) begin
               cmd.bal_rd = 1'b1;
               state_in   = S_MOVE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_MOVE: begin
            cmd.bal_wr = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/miq_dpath.sv
// ---------------------------------------------------------------------------
// miq_dpath
// Two circular element stores with head and count registers, request latch
// and response register.
// ---------------------------------------------------------------------------
module miq_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  miq_pkg::miq_cmd_type  cmd,
   output miq_pkg::miq_stat_type stat,
   input  logic [1:0]            req_op,
   input  logic [31:0]           req_value,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_popped_value,
   output logic [1:0]            rsp_status
);

   localparam int AW = miq_pkg::ADDR_W;
   localparam int CW = miq_pkg::CNT_W;
   localparam int VW = miq_pkg::VALUE_W;

   logic [VW-1:0] front_store [miq_pkg::HALF_DEPTH];
   logic [VW-1:0] back_store  [miq_pkg::HALF_DEPTH];

   logic [1:0]    op_ff;
   logic [VW-1:0] value_ff;
   logic [VW-1:0] popped_ff;
   logic [1:0]    status_ff;
   logic [VW-1:0] front_rd_ff;
   logic [VW-1:0] back_rd_ff;

   logic [AW-1:0] front_head_ff, front_head_in;
   logic [CW-1:0] front_count_ff, front_count_in;
   logic [AW-1:0] back_head_ff, back_head_in;
   logic [CW-1:0] back_count_ff, back_count_in;

   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_data_ff;
   logic [1:0]    rsp_st_ff;

   logic [AW-1:0] back_tail;
   logic [AW-1:0] back_wr_addr;
   logic [AW-1:0] front_tail;

   assign back_tail  = miq_pkg::wrap_sum({1'b0, back_head_ff} + (AW + 1)'(back_count_ff));
   assign front_tail = miq_pkg::wrap_sum({1'b0, front_head_ff} + (AW + 1)'(front_count_ff));
   assign back_wr_addr = cmd.push_mid ? miq_pkg::dec_idx(back_head_ff) : back_tail;

   assign stat.op       = op_ff;
   assign stat.empty    = (front_count_ff == '0);
   assign stat.full     = (back_count_ff == CW'(miq_pkg::HALF_DEPTH));
   assign stat.need_bal = (back_count_ff > front_count_ff);
   assign stat.rsp_free = !rsp_valid_ff || rsp_tready;

   // Head and count updates
   always_comb begin
      front_head_in  = front_head_ff;
      front_count_in = front_count_ff;
      back_head_in   = back_head_ff;
      back_count_in  = back_count_ff;
      if (cmd.push_tail || cmd.push_mid) begin
         back_count_in = back_count_ff + 1'b1;
      end
      if (cmd.push_mid) begin
         back_head_in = miq_pkg::dec_idx(back_head_ff);
      end
      if (cmd.pop) begin
         front_head_in  = miq_pkg::inc_idx(front_head_ff);
         front_count_in = front_count_ff - 1'b1;
      end
      if (cmd.bal_rd) begin
         back_head_in  = miq_pkg::inc_idx(back_head_ff);
         back_count_in = back_count_ff - 1'b1;
      end
      if (cmd.bal_wr) begin
         front_count_in = front_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_head_ff  <= '0;
         front_count_ff <= '0;
         back_head_ff   <= '0;
         back_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         front_head_ff  <= front_head_in;
         front_count_ff <= front_count_in;
         back_head_ff   <= back_head_in;
         back_count_ff  <= back_count_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= req_op;
         value_ff  <= VW'(req_value);
         popped_ff <= '0;
      end
      if (cmd.cap_pop) begin
         popped_ff <= front_rd_ff;
      end
      if (cmd.set_st) begin
         status_ff <= cmd.st_code;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= popped_ff;
         rsp_st_ff   <= status_ff;
      end
   end

   // Back store: pushes write, rebalance reads the head
   always_ff @(posedge clock) begin
      if (cmd.push_tail || cmd.push_mid) begin
         back_store[back_wr_addr] <= value_ff;
      end
      if (cmd.bal_rd) begin
         back_rd_ff <= back_store[back_head_ff];
      end
   end

   // Front store: rebalance writes the tail, pop reads the head
   always_ff @(posedge clock) begin
      if (cmd.bal_wr) begin
         front_store[front_tail] <= back_rd_ff;
      end
      if (cmd.pop) begin
         front_rd_ff <= front_store[front_head_ff];
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_popped_value = 32'(rsp_data_ff);
   assign rsp_status       = rsp_st_ff;

endmodule

### rtl/middle_insert_queue.sv
// ---------------------------------------------------------------------------
// middle_insert_queue
// Queue with push at tail, push into the middle and pop at head.
// ---------------------------------------------------------------------------
// Sequencing: a request steps through operation, store read, rebalance move
//   and response load. A dropped push, a pop on an empty queue or an unused
//   op code skips the store read and the move; the move is skipped as well
//   when the back half is not longer than the front half. A new request is
//   taken only after the response register is loaded, and a stalled response
//   holds the sequencer until rsp_tready frees the register.
// Reset: synchronous, active high; both halves empty, no response pending.
//   Store contents are not cleared, so there is no clearing pass.
// ---------------------------------------------------------------------------
module middle_insert_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] popped_value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   // The queue is split into a front FIFO and a back deque. Tail pushes land
   // at the back of the deque, middle pushes at its front. After each
   // operation the deque head moves to the FIFO tail whenever the back half
   // is the longer one, so the middle of the queue is always the deque head.

   miq_pkg::miq_cmd_type  cmd;
   miq_pkg::miq_stat_type stat;

   // Sequencer: one request in flight, response register decouples the sink
   miq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Stores, pointers and the response register
   miq_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_tuser),
      .req_value        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_popped_value (rsp_tdata),
      .rsp_status       (rsp_tuser)
   );

endmodule

### rtl/miq_checker.sv
// ---------------------------------------------------------------------------
// miq_checker
// Port-level checks of the middle insert queue, bound to the top level.
// ---------------------------------------------------------------------------
module miq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // No response pending straight after reset
   a_rst_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Only one request in flight: ready drops after each transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in flight");

   // Failed results (empty or full status) carry a zero value
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == miq_pkg::ST_EMPTY || rsp_tuser == miq_pkg::ST_FULL)
      |-> rsp_tdata == 32'd0)
      else $error("non-zero value with failure status");

   // Status stays within its codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == miq_pkg::ST_OK || rsp_tuser == miq_pkg::ST_EMPTY
                      || rsp_tuser == miq_pkg::ST_FULL))
      else $error("unknown status code");

endmodule

bind middle_insert_queue miq_checker u_miq_checker (.*);
